>>> rtl/core/ellipsoid_neighbour_mask_match_macros.svh
// Assertion shorthands used by the checker.
`ifndef ELLIPSOID_NEIGHBOUR_MASK_MATCH_MACROS_SVH
`define ELLIPSOID_NEIGHBOUR_MASK_MATCH_MACROS_SVH

// General property, checked on the rising clock, off while in reset.
`define ENMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Cause in one cycle, effect in the next.
`define ENMM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/enmm_pkg.sv
package enmm_pkg;

  // Defaults and fixed limits
  localparam int MAX_DIM_DEF = 64;
  localparam int MAX_RADIUS  = 15;

  // Field and register widths
  localparam int GRID_REG_W = 7;
  localparam int RAD_REG_W  = 4;
  localparam int VOXEL_W    = 18;
  localparam int COORD_W    = 6;
  localparam int OFF_W      = 5;
  localparam int ROW_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USED_W  = 52;
  localparam int OUT_DATA_W = 72;

  // Ellipsoid arithmetic widths (radius at most 15, offset down to -16)
  localparam int SQ_W   = 9;
  localparam int R2_W   = 8;
  localparam int PAIR_W = 16;
  localparam int TRI_W  = 24;
  localparam int TERM_W = 25;
  localparam int SUM_W  = 27;
  localparam int CAND_W = 8;

  // Reset values of the configuration registers
  localparam logic [GRID_REG_W-1:0] GRID_RST   = 7'd64;
  localparam logic [RAD_REG_W-1:0]  RADIUS_RST = 4'd1;

  // Cycles the coefficient products need after a register write
  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X,
    CFG_GRID_Y,
    CFG_GRID_Z,
    CFG_RADIUS_X,
    CFG_RADIUS_Y,
    CFG_RADIUS_Z
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_PUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mask_wr;
    logic row_adv;
    logic stage_x;
    logic stage_y;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
  } sts_t;

  // Square of a signed offset
  function automatic logic [SQ_W-1:0] sq_off(logic signed [OFF_W-1:0] v);
    logic signed [SQ_W:0] p;
    p = v * v;
    return p[SQ_W-1:0];
  endfunction

endpackage

>>> rtl/core/ellipsoid_neighbour_mask_match.sv
// Ellipsoid neighbour mask matcher. Mask words (tuser 0) write one internal-point bit
// into a MAX_DIM^3-bit memory and take one cycle each; the memory holds no defined value
// until written, so every voxel in use must be loaded before candidates arrive.
// Candidate words (tuser 1) go through capture, a product stage for the weighted offset
// squares and plane offsets, an index stage that forms the linear index, compares
// against the ellipsoid bound and reads the mask memory, and a result stage that loads
// the output register on a hit. On a hit the result stage waits while an earlier
// result is still held on the master side. After reset and after each register write
// the slave side stays not ready while the radius products are rebuilt. tlast on a
// candidate word advances the row counter once the word is taken.
module ellipsoid_neighbour_mask_match import enmm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // voxel_index[17:0], mask_bit[18], ep_x[24:19], ep_y[30:25], ep_z[36:31],
  // off_x[41:37], off_y[46:42], off_z[51:47], zero pad[55:52]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,   // last_offset
  input  logic                  s_axis_tuser,   // mode
  // Master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // ep_index[17:0], row_index[35:18], ip_index[53:36],
  // disp_x[58:54], disp_y[63:59], disp_z[68:64], zero pad[71:69]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  enmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  enmm_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata[IN_USED_W-1:0]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule

>>> rtl/core/enmm_ctrl.sv
module enmm_ctrl import enmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_mode_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic cfg_we_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [SETTLE_W-1:0]  settle_q, settle_d;
  logic                 accept;
  logic                 push_ok;

  assign in_ready_o  = (state_q == ST_IDLE) && (settle_q == '0);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign push_ok     = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_mode_i) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_IDX;
      ST_IDX:  state_d = ST_PUSH;
      ST_PUSH: begin
        if (!sts_i.hit || push_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept && in_mode_i;
    cmd_o.mask_wr  = accept && !in_mode_i;
    cmd_o.row_adv  = accept && in_mode_i && in_last_i;
    cmd_o.stage_x  = (state_q == ST_MUL);
    cmd_o.stage_y  = (state_q == ST_IDX);
    cmd_o.out_load = (state_q == ST_PUSH) && sts_i.hit && push_ok;
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // Hold off input while coefficient products settle
  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) settle_d = SETTLE_CYCLES;
    else if (settle_q != '0) settle_d = settle_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      settle_q    <= SETTLE_CYCLES;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      settle_q    <= settle_d;
    end
  end

endmodule

>>> rtl/core/enmm_dpath.sv
module enmm_dpath import enmm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_USED_W-1:0]  in_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int     DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam longint NVOX  = longint'(MAX_DIM) * MAX_DIM * MAX_DIM;
  localparam int     AW    = $clog2(DEPTH);
  localparam int     PW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int     CW    = $clog2(MAX_DIM);
  localparam int     GW    = $clog2(MAX_DIM + 1);
  localparam int     CMP_W = (GW > GRID_REG_W) ? GW : GRID_REG_W;

  // Configuration registers
  logic [GRID_REG_W-1:0] grid_x_q, grid_y_q, grid_z_q;
  logic [RAD_REG_W-1:0]  rad_x_q, rad_y_q, rad_z_q;

  // Saturated settings
  logic [GW-1:0]        gx_sat, gy_sat, gz_sat;
  logic [RAD_REG_W-1:0] rx_sat, ry_sat, rz_sat;

  // Coefficient products
  logic [R2_W-1:0]   r2x_q, r2y_q, r2z_q;
  logic [PAIR_W-1:0] pyz_q, pxz_q, pxy_q;
  logic [TRI_W-1:0]  rhs_q;
  logic              rad_zero_q;

  // Input word fields
  logic [VOXEL_W-1:0]      in_voxel;
  logic                    in_mbit;
  logic [COORD_W-1:0]      in_ex, in_ey, in_ez;
  logic signed [OFF_W-1:0] in_ox, in_oy, in_oz;

  // Captured candidate
  logic [COORD_W-1:0]      ex_q, ey_q, ez_q;
  logic signed [OFF_W-1:0] ox_q, oy_q, oz_q;
  logic [SQ_W-1:0]         osqx_q, osqy_q, osqz_q;
  logic signed [OFF_W-1:0] dispx_q, dispy_q, dispz_q;
  logic [VOXEL_W-1:0]      row_cap_q;
  logic [ROW_W-1:0]        row_q;

  // Product stage
  logic signed [CAND_W-1:0] cx_c, cy_c, cz_c;
  logic                     ok_x, ok_y, ok_z;
  logic [TERM_W-1:0]        termx_q, termy_q, termz_q;
  logic                     inb_q;
  logic [CW-1:0]            cx_q, ex_cw_q;
  logic [PW-1:0]            czy_q, ezy_q;

  // Index stage
  logic [SUM_W-1:0] sum_d;
  logic             ell_ok;
  logic [AW-1:0]    ipi_d, epi_d;
  logic [AW-1:0]    ipi_q, epi_q;
  logic             hit_q;
  logic             rd_q;

  logic             mask_mem_q [DEPTH];
  logic             wr_in_range;

  logic [OUT_DATA_W-1:0] out_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= GRID_RST;
      grid_y_q <= GRID_RST;
      grid_z_q <= GRID_RST;
      rad_x_q  <= RADIUS_RST;
      rad_y_q  <= RADIUS_RST;
      rad_z_q  <= RADIUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_X:   grid_x_q <= cfg_data_i;
        CFG_GRID_Y:   grid_y_q <= cfg_data_i;
        CFG_GRID_Z:   grid_z_q <= cfg_data_i;
        CFG_RADIUS_X: rad_x_q  <= cfg_data_i[RAD_REG_W-1:0];
        CFG_RADIUS_Y: rad_y_q  <= cfg_data_i[RAD_REG_W-1:0];
        CFG_RADIUS_Z: rad_z_q  <= cfg_data_i[RAD_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp settings to the supported range
  assign gx_sat = (grid_x_q > MAX_DIM) ? GW'(MAX_DIM) : GW'(grid_x_q);
  assign gy_sat = (grid_y_q > MAX_DIM) ? GW'(MAX_DIM) : GW'(grid_y_q);
  assign gz_sat = (grid_z_q > MAX_DIM) ? GW'(MAX_DIM) : GW'(grid_z_q);
  assign rx_sat = (rad_x_q > MAX_RADIUS) ? RAD_REG_W'(MAX_RADIUS) : rad_x_q;
  assign ry_sat = (rad_y_q > MAX_RADIUS) ? RAD_REG_W'(MAX_RADIUS) : rad_y_q;
  assign rz_sat = (rad_z_q > MAX_RADIUS) ? RAD_REG_W'(MAX_RADIUS) : rad_z_q;

  // Build the ellipsoid coefficients: squared radii, then pair products, then the bound
  always_ff @(posedge clk_i) begin
    r2x_q      <= R2_W'(rx_sat) * R2_W'(rx_sat);
    r2y_q      <= R2_W'(ry_sat) * R2_W'(ry_sat);
    r2z_q      <= R2_W'(rz_sat) * R2_W'(rz_sat);
    rad_zero_q <= (rx_sat == '0) || (ry_sat == '0) || (rz_sat == '0);
    pyz_q      <= PAIR_W'(r2y_q) * PAIR_W'(r2z_q);
    pxz_q      <= PAIR_W'(r2x_q) * PAIR_W'(r2z_q);
    pxy_q      <= PAIR_W'(r2x_q) * PAIR_W'(r2y_q);
    rhs_q      <= TRI_W'(r2x_q) * TRI_W'(pyz_q);
  end

  // Unpack the input word
  assign in_voxel = in_data_i[17:0];
  assign in_mbit  = in_data_i[18];
  assign in_ex    = in_data_i[24:19];
  assign in_ey    = in_data_i[30:25];
  assign in_ez    = in_data_i[36:31];
  assign in_ox    = in_data_i[41:37];
  assign in_oy    = in_data_i[46:42];
  assign in_oz    = in_data_i[51:47];

  // Count external voxels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (cmd_i.row_adv) begin
      row_q <= row_q + 1'b1;
    end
  end

  // Capture a candidate
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ex_q      <= in_ex;
      ey_q      <= in_ey;
      ez_q      <= in_ez;
      ox_q      <= in_ox;
      oy_q      <= in_oy;
      oz_q      <= in_oz;
      osqx_q    <= sq_off(in_ox);
      osqy_q    <= sq_off(in_oy);
      osqz_q    <= sq_off(in_oz);
      dispx_q   <= -in_ox;
      dispy_q   <= -in_oy;
      dispz_q   <= -in_oz;
      row_cap_q <= row_q[VOXEL_W-1:0];
    end
  end

  // Candidate voxel and grid bounds
  assign cx_c = CAND_W'($signed({1'b0, ex_q})) + CAND_W'(ox_q);
  assign cy_c = CAND_W'($signed({1'b0, ey_q})) + CAND_W'(oy_q);
  assign cz_c = CAND_W'($signed({1'b0, ez_q})) + CAND_W'(oz_q);

  assign ok_x = !cx_c[CAND_W-1] && (CMP_W'(cx_c[CAND_W-2:0]) < CMP_W'(gx_sat))
                && (CMP_W'(ex_q) < CMP_W'(gx_sat));
  assign ok_y = !cy_c[CAND_W-1] && (CMP_W'(cy_c[CAND_W-2:0]) < CMP_W'(gy_sat))
                && (CMP_W'(ey_q) < CMP_W'(gy_sat));
  assign ok_z = !cz_c[CAND_W-1] && (CMP_W'(cz_c[CAND_W-2:0]) < CMP_W'(gz_sat))
                && (CMP_W'(ez_q) < CMP_W'(gz_sat));

  // Product stage: weighted squares and plane offsets
  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_x) begin
      termx_q <= TERM_W'(osqx_q) * TERM_W'(pyz_q);
      termy_q <= TERM_W'(osqy_q) * TERM_W'(pxz_q);
      termz_q <= TERM_W'(osqz_q) * TERM_W'(pxy_q);
      inb_q   <= ok_x && ok_y && ok_z;
      cx_q    <= CW'(cx_c[CAND_W-2:0]);
      ex_cw_q <= CW'(ex_q);
      czy_q   <= PW'(cz_c[CAND_W-2:0]) * PW'(gy_sat) + PW'(cy_c[CAND_W-2:0]);
      ezy_q   <= PW'(ez_q) * PW'(gy_sat) + PW'(ey_q);
    end
  end

  // Index stage: ellipsoid compare and linear indices
  assign sum_d  = SUM_W'(termx_q) + SUM_W'(termy_q) + SUM_W'(termz_q);
  assign ell_ok = (sum_d <= SUM_W'(rhs_q));
  assign ipi_d  = AW'(czy_q) * AW'(gx_sat) + AW'(cx_q);
  assign epi_d  = AW'(ezy_q) * AW'(gx_sat) + AW'(ex_cw_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_y) begin
      ipi_q <= ipi_d;
      epi_q <= epi_d;
      hit_q <= inb_q && ell_ok && !rad_zero_q;
    end
  end

  // Mask memory: write on a mask word, read at the candidate index
  assign wr_in_range = (64'(in_voxel) < NVOX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mask_wr && wr_in_range) begin
      mask_mem_q[AW'(in_voxel)] <= in_mbit;
    end
    if (cmd_i.stage_y) begin
      rd_q <= inb_q ? mask_mem_q[ipi_d] : 1'b0;
    end
  end

  assign sts_o.hit = hit_q && rd_q;

  // Result word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {3'b000, dispz_q, dispy_q, dispx_q,
                VOXEL_W'(ipi_q), row_cap_q, VOXEL_W'(epi_q)};
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/core/enmm_checker.sv
`include "ellipsoid_neighbour_mask_match_macros.svh"

module enmm_checker import enmm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  cfg_we_i
);

  logic in_word;
  assign in_word = s_axis_tvalid && s_axis_tready;

  // Held result word stays put
  `ENMM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // A candidate keeps the slave side closed while it is worked on
  `ENMM_ASSERT_NEXT(a_cand_busy, in_word && s_axis_tuser, !s_axis_tready, "ready while a candidate is in flight")

  // A register write closes the slave side while products settle
  `ENMM_ASSERT_NEXT(a_cfg_settle, cfg_we_i, !s_axis_tready, "ready right after a register write")

  // Unless a register write comes with it, a mask word leaves the slave side ready in the next cycle
  `ENMM_ASSERT_NEXT(a_mask_fast, in_word && !s_axis_tuser && !cfg_we_i, s_axis_tready, "not ready after a mask word")

  // A fresh result follows an accepted candidate through the product, index and result states
  `ENMM_ASSERT(a_out_latency, $rose(m_axis_tvalid) |-> $past(in_word && s_axis_tuser, 4), "result without a matching candidate")

endmodule

bind ellipsoid_neighbour_mask_match enmm_checker u_enmm_checker (.*);

>>> sim/ellipsoid_neighbour_mask_match_test.sv
`timescale 1ns / 100ps

module ellipsoid_neighbour_mask_match_test;
  import enmm_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int QUIET_CYCLES  = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int WORD_TARGET   = 950;
  localparam int LOAD_DENSITY  = 60;
  localparam int PHASE_WORDS   = 50;
  localparam int NUM_VOXELS    = 1 << VOXEL_W;

  // Feed queue entry kinds
  localparam logic [1:0] OP_WORD = 2'd0;
  localparam logic [1:0] OP_CFG  = 2'd1;
  localparam logic [1:0] OP_HOLD = 2'd2;

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Idle percentages per phase: none, sender, receiver, both
  localparam logic [3:0][7:0] SEND_GAP_PCT   = {8'd8, 8'd0, 8'd69, 8'd0};
  localparam logic [3:0][7:0] RECV_STALL_PCT = {8'd8, 8'd69, 8'd0, 8'd0};

  typedef struct packed {
    logic [VOXEL_W-1:0] ep_index;
    logic [VOXEL_W-1:0] row_index;
    logic [VOXEL_W-1:0] ip_index;
    logic [OFF_W-1:0]   disp_x;
    logic [OFF_W-1:0]   disp_y;
    logic [OFF_W-1:0]   disp_z;
  } match_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  mode;
    logic [VOXEL_W-1:0]    voxel;
    logic                  mbit;
    logic [COORD_W-1:0]    ex;
    logic [COORD_W-1:0]    ey;
    logic [COORD_W-1:0]    ez;
    logic [OFF_W-1:0]      ox;
    logic [OFF_W-1:0]      oy;
    logic [OFF_W-1:0]      oz;
    logic                  last;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  has_hit;
    match_t                hit;
  } feed_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ellipsoid_neighbour_mask_match dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Queues between stimulus, driver and checker
  feed_t  feed_q[$];
  feed_t  batch_q[$];
  match_t pending_matches[$];

  // Shadow of the block state used to predict matches
  bit                    mask_mem [0:NUM_VOXELS-1];
  bit                    loaded   [0:NUM_VOXELS-1];
  logic [ROW_W-1:0]      row_ctr = '0;
  logic [GRID_REG_W-1:0] sh_grid [3];
  logic [RAD_REG_W-1:0]  sh_rad  [3];

  int          n_words;
  int          n_hits;
  int          n_cfg;
  int          n_rounds;
  int          n_seen;
  int          n_bad;
  int          n_cycles;
  int unsigned n_taken;
  int unsigned idle_phase;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int eff_grid(int a);
    int g;
    g = sh_grid[a];
    return (g > MAX_DIM_DEF) ? MAX_DIM_DEF : g;
  endfunction

  // Linear index of the candidate voxel; false when it falls off the grid
  function automatic bit cand_index(input feed_t w, output int idx);
    int cx, cy, cz, gx, gy, gz;
    gx  = eff_grid(0);
    gy  = eff_grid(1);
    gz  = eff_grid(2);
    cx  = int'(w.ex) + int'($signed(w.ox));
    cy  = int'(w.ey) + int'($signed(w.oy));
    cz  = int'(w.ez) + int'($signed(w.oz));
    idx = (cz * gy + cy) * gx + cx;
    return cx >= 0 && cy >= 0 && cz >= 0 && cx < gx && cy < gy && cz < gz;
  endfunction

  // Apply one word to the shadow state and fill in the match it causes
  task automatic match_word(inout feed_t w);
    int     ipi, epi, ex, ey, ez, ox, oy, oz, r0, r1, r2, gx, gy, nx, ny, nz;
    longint rx2, ry2, rz2, lhs;
    bit     hit;
    w.has_hit = 1'b0;
    w.hit     = '0;
    if (!w.mode) begin
      mask_mem[w.voxel] = w.mbit;
      loaded[w.voxel]   = 1'b1;
    end else begin
      ex  = w.ex;
      ey  = w.ey;
      ez  = w.ez;
      ox  = $signed(w.ox);
      oy  = $signed(w.oy);
      oz  = $signed(w.oz);
      r0  = sh_rad[0];
      r1  = sh_rad[1];
      r2  = sh_rad[2];
      rx2 = r0 * r0;
      ry2 = r1 * r1;
      rz2 = r2 * r2;
      lhs = ox * ox * ry2 * rz2 + oy * oy * rx2 * rz2 + oz * oz * rx2 * ry2;
      hit = rx2 != 0 && ry2 != 0 && rz2 != 0 && lhs <= rx2 * ry2 * rz2;
      gx  = eff_grid(0);
      gy  = eff_grid(1);
      if (ex >= gx || ey >= gy || ez >= eff_grid(2)) hit = 1'b0;
      if (!cand_index(w, ipi)) hit = 1'b0;
      if (hit) hit = mask_mem[ipi];
      if (hit) begin
        epi             = (ez * gy + ey) * gx + ex;
        nx              = -ox;
        ny              = -oy;
        nz              = -oz;
        w.has_hit       = 1'b1;
        w.hit.ep_index  = epi[VOXEL_W-1:0];
        w.hit.row_index = row_ctr[VOXEL_W-1:0];
        w.hit.ip_index  = ipi[VOXEL_W-1:0];
        w.hit.disp_x    = nx[OFF_W-1:0];
        w.hit.disp_y    = ny[OFF_W-1:0];
        w.hit.disp_z    = nz[OFF_W-1:0];
      end
      if (w.last) row_ctr = row_ctr + 1'b1;
    end
  endtask

  function automatic feed_t mask_word(int idx, bit b);
    feed_t w;
    w       = '0;
    w.kind  = OP_WORD;
    w.voxel = idx[VOXEL_W-1:0];
    w.mbit  = b;
    w.ex    = COORD_W'($urandom_range(0, 63));
    w.ey    = COORD_W'($urandom_range(0, 63));
    w.ez    = COORD_W'($urandom_range(0, 63));
    w.ox    = OFF_W'($urandom_range(0, 31));
    w.oy    = OFF_W'($urandom_range(0, 31));
    w.oz    = OFF_W'($urandom_range(0, 31));
    w.last  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic feed_t cand(int ex, int ey, int ez, int ox, int oy, int oz, bit last);
    feed_t w;
    w       = '0;
    w.kind  = OP_WORD;
    w.mode  = 1'b1;
    w.voxel = VOXEL_W'($urandom_range(0, NUM_VOXELS - 1));
    w.mbit  = 1'($urandom_range(0, 1));
    w.ex    = ex[COORD_W-1:0];
    w.ey    = ey[COORD_W-1:0];
    w.ez    = ez[COORD_W-1:0];
    w.ox    = ox[OFF_W-1:0];
    w.oy    = oy[OFF_W-1:0];
    w.oz    = oz[OFF_W-1:0];
    w.last  = last;
    return w;
  endfunction

  // Append one entry to the current batch
  task automatic queue_batch(input feed_t w);
    batch_q.insert(batch_q.size(), w);
  endtask

  task automatic emit_word(input feed_t w);
    match_word(w);
    if (w.has_hit) n_hits++;
    n_words++;
    feed_q.insert(feed_q.size(), w);
  endtask

  // Load every in-grid mask entry the batch reads before it, then release the batch
  task automatic flush_batch();
    int idx;
    foreach (batch_q[i]) begin
      if (batch_q[i].mode && cand_index(batch_q[i], idx) && !loaded[idx])
        emit_word(mask_word(idx, $urandom_range(0, 99) < LOAD_DENSITY));
    end
    foreach (batch_q[i]) emit_word(batch_q[i]);
    batch_q.delete();
  endtask

  task automatic put_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    feed_t w;
    w         = '0;
    w.kind    = OP_CFG;
    w.reg_idx = idx;
    w.reg_val = val;
    case (idx)
      CFG_GRID_X:   sh_grid[0] = val;
      CFG_GRID_Y:   sh_grid[1] = val;
      CFG_GRID_Z:   sh_grid[2] = val;
      CFG_RADIUS_X: sh_rad[0]  = val[RAD_REG_W-1:0];
      CFG_RADIUS_Y: sh_rad[1]  = val[RAD_REG_W-1:0];
      CFG_RADIUS_Z: sh_rad[2]  = val[RAD_REG_W-1:0];
      default: ;
    endcase
    n_cfg++;
    feed_q.insert(feed_q.size(), w);
  endtask

  task automatic put_hold();
    feed_t w;
    w      = '0;
    w.kind = OP_HOLD;
    feed_q.insert(feed_q.size(), w);
  endtask

  // One external voxel: offsets over a box, x outermost, z innermost
  task automatic seq_voxel(int ex, int ey, int ez, int lx, int ly, int lz, bit close);
    for (int i = -lx; i <= lx; i++)
      for (int j = -ly; j <= ly; j++)
        for (int k = -lz; k <= lz; k++)
          queue_batch(cand(ex, ey, ez, i, j, k,
                           close && i == lx && j == ly && k == lz));
  endtask

  task automatic noise_burst(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1))
        queue_batch(mask_word($urandom_range(0, NUM_VOXELS - 1), 1'($urandom_range(0, 1))));
      else
        queue_batch(cand($urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 31) - 16,
                         $urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16,
                         1'($urandom_range(0, 1))));
    end
  endtask

  // Stimulus
  initial begin : stim
    int g_new[3];
    int r_new[3];
    int lim[3];
    int line_axis, gx, gy, gz, nvox, v, cnt, pick;
    int offs[6];
    offs = '{-16, -15, -8, 0, 8, 15};
    for (int a = 0; a < 3; a++) begin
      sh_grid[a] = GRID_RST;
      sh_rad[a]  = RADIUS_RST;
    end

    // Reset settings: full grid, unit sphere, corners of the volume
    queue_batch(mask_word(0, 1'b1));
    queue_batch(mask_word(1, 1'b1));
    queue_batch(mask_word(64, 1'b1));
    queue_batch(mask_word(4096, 1'b1));
    queue_batch(mask_word(NUM_VOXELS - 1, 1'b1));
    queue_batch(mask_word(NUM_VOXELS - 2, 1'b0));
    queue_batch(cand(0, 0, 0, 0, 0, 0, 1'b0));
    queue_batch(cand(0, 0, 0, 1, 0, 0, 1'b0));
    queue_batch(cand(0, 0, 0, 0, 1, 0, 1'b0));
    queue_batch(cand(0, 0, 0, 0, 0, 1, 1'b0));
    queue_batch(cand(0, 0, 0, -1, 0, 0, 1'b0));
    queue_batch(cand(0, 0, 0, 1, 1, 0, 1'b0));
    queue_batch(cand(0, 0, 0, 15, 15, 15, 1'b1));
    queue_batch(cand(63, 63, 63, 0, 0, 0, 1'b0));
    queue_batch(cand(63, 63, 63, -1, 0, 0, 1'b0));
    queue_batch(cand(63, 63, 63, 1, 0, 0, 1'b0));
    queue_batch(cand(63, 63, 63, 0, 0, -1, 1'b0));
    queue_batch(cand(63, 63, 63, -16, -16, -16, 1'b1));
    flush_batch();

    // Long thin grids with the largest radius on each axis in turn
    put_cfg(CFG_GRID_Y, 7'd1);
    put_cfg(CFG_GRID_Z, 7'd1);
    put_cfg(CFG_RADIUS_X, 7'h7F);
    foreach (offs[i]) queue_batch(cand(31, 0, 0, offs[i], 0, 0, i == 5));
    flush_batch();
    put_cfg(CFG_GRID_X, 7'd1);
    put_cfg(CFG_GRID_Y, 7'd64);
    put_cfg(CFG_RADIUS_X, 7'd1);
    put_cfg(CFG_RADIUS_Y, 7'd15);
    foreach (offs[i]) queue_batch(cand(0, 40, 0, 0, offs[i], 0, i == 5));
    flush_batch();
    put_cfg(CFG_GRID_Y, 7'd1);
    put_cfg(CFG_GRID_Z, 7'd64);
    put_cfg(CFG_RADIUS_Y, 7'd1);
    put_cfg(CFG_RADIUS_Z, 7'd15);
    foreach (offs[i]) queue_batch(cand(0, 0, 15, 0, 0, offs[i], i == 5));
    flush_batch();

    // Grid register above the limit saturates
    put_cfg(CFG_GRID_X, 7'd127);
    put_cfg(CFG_GRID_Z, 7'd1);
    put_cfg(CFG_RADIUS_X, 7'd9);
    put_cfg(CFG_RADIUS_Z, 7'd1);
    queue_batch(cand(63, 0, 0, -9, 0, 0, 1'b0));
    queue_batch(cand(63, 0, 0, 0, 0, 0, 1'b1));
    flush_batch();

    // Zero radius, then zero grid: nothing can match
    put_cfg(CFG_GRID_X, 7'd3);
    put_cfg(CFG_GRID_Y, 7'd3);
    put_cfg(CFG_GRID_Z, 7'd3);
    put_cfg(CFG_RADIUS_X, 7'd0);
    seq_voxel(1, 1, 1, 0, 1, 1, 1'b1);
    flush_batch();
    put_cfg(CFG_RADIUS_X, 7'd1);
    put_cfg(CFG_GRID_X, 7'd0);
    seq_voxel(0, 1, 1, 1, 0, 0, 1'b1);
    flush_batch();

    // Hold the sender until every match so far has drained
    put_hold();

    // Writes past the register list are dropped
    put_cfg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 127)));
    put_cfg(CFG_SPARE_HI, 7'h7F);

    // Random settings, each with a walk over external voxels in ascending order
    while (n_words < WORD_TARGET) begin
      n_rounds++;
      line_axis = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
      for (int a = 0; a < 3; a++) begin
        if (line_axis == 3) begin
          g_new[a] = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 127)
                                                 : $urandom_range(1, 6);
          r_new[a] = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 15)
                                                 : $urandom_range(1, 3);
          lim[a]   = $urandom_range(0, (r_new[a] > 2) ? 2 : r_new[a]);
        end else if (a == line_axis) begin
          g_new[a] = $urandom_range(16, 127);
          r_new[a] = $urandom_range(6, 15);
          lim[a]   = r_new[a];
        end else begin
          g_new[a] = 1;
          r_new[a] = $urandom_range(1, 15);
          lim[a]   = 0;
        end
      end
      put_cfg(CFG_GRID_X, CFG_DATA_W'(g_new[0]));
      put_cfg(CFG_GRID_Y, CFG_DATA_W'(g_new[1]));
      put_cfg(CFG_GRID_Z, CFG_DATA_W'(g_new[2]));
      put_cfg(CFG_RADIUS_X, CFG_DATA_W'(r_new[0]));
      put_cfg(CFG_RADIUS_Y, CFG_DATA_W'(r_new[1]));
      put_cfg(CFG_RADIUS_Z, CFG_DATA_W'(r_new[2]));

      gx   = eff_grid(0);
      gy   = eff_grid(1);
      gz   = eff_grid(2);
      nvox = gx * gy * gz;
      v    = $urandom_range(0, nvox / 4);
      cnt  = 0;
      while (v < nvox && cnt < 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          seq_voxel(v % gx, (v / gx) % gy, v / (gx * gy), lim[0], lim[1], lim[2], 1'b1);
        else if (pick < 90)
          seq_voxel(v % gx, (v / gx) % gy, v / (gx * gy), lim[0], lim[1], lim[2], 1'b0);
        else
          noise_burst($urandom_range(3, 10));
        v += $urandom_range(1, nvox / 3 + 1);
        cnt++;
      end
      flush_batch();
      // Let every match drain once with the sender held back
      if (n_rounds == 4) put_hold();
    end

    // Wait for the feed to empty and every match to come back
    wait (rst_ni);
    while (feed_q.size() != 0 || s_axis_tvalid || pending_matches.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Fed %0d words over %0d register writes and %0d random settings.",
             n_words, n_cfg, n_rounds);
    $display("Predicted %0d neighbour matches, checked %0d, %0d errors.",
             n_hits, n_seen, n_bad);
    if (n_bad == 0) begin
      $display("ellipsoid_neighbour_mask_match: match");
    end else begin
      $display("ellipsoid_neighbour_mask_match: mismatch");
    end
    $finish;
  end

  // Driver: present words, perform register writes once the block is idle
  always @(posedge clk_i) begin : feed_drive
    feed_t                 head;
    feed_t                 in_flight;
    int                    quiet;
    logic                  nxt_valid, nxt_last, nxt_mode, nxt_we;
    logic [IN_DATA_W-1:0]  nxt_data;
    logic [CFG_IDX_W-1:0]  nxt_idx;
    logic [CFG_DATA_W-1:0] nxt_val;
    if (rst_ni) begin
      nxt_valid = s_axis_tvalid;
      nxt_data  = s_axis_tdata;
      nxt_last  = s_axis_tlast;
      nxt_mode  = s_axis_tuser;
      nxt_we    = 1'b0;
      nxt_idx   = cfg_idx_i;
      nxt_val   = cfg_data_i;

      // Record the accepted word
      if (s_axis_tvalid && s_axis_tready) begin
        if (in_flight.has_hit)
          pending_matches.insert(pending_matches.size(), in_flight.hit);
        n_taken++;
        idle_phase = (n_taken / PHASE_WORDS) % 4;
        quiet      = 0;
        nxt_valid  = 1'b0;
      end else if (quiet < QUIET_CYCLES) begin
        quiet++;
      end

      // Take the next queue entry
      if (!nxt_valid && feed_q.size() != 0) begin
        head = feed_q[0];
        case (head.kind)
          OP_WORD: begin
            if ($urandom_range(0, 99) >= SEND_GAP_PCT[idle_phase]) begin
              head      = feed_q.pop_front();
              in_flight = head;
              nxt_valid = 1'b1;
              nxt_mode  = head.mode;
              nxt_last  = head.last;
              nxt_data  = {{(IN_DATA_W - IN_USED_W){1'b0}}, head.oz, head.oy, head.ox,
                           head.ez, head.ey, head.ex, head.mbit, head.voxel};
            end
          end
          OP_CFG: begin
            if (pending_matches.size() == 0 && quiet >= QUIET_CYCLES && !m_axis_tvalid) begin
              head    = feed_q.pop_front();
              nxt_we  = 1'b1;
              nxt_idx = head.reg_idx;
              nxt_val = head.reg_val;
            end
          end
          default: begin
            if (pending_matches.size() == 0) head = feed_q.pop_front();
          end
        endcase
      end

      s_axis_tvalid <= nxt_valid;
      s_axis_tdata  <= nxt_data;
      s_axis_tlast  <= nxt_last;
      s_axis_tuser  <= nxt_mode;
      cfg_we_i      <= nxt_we;
      cfg_idx_i     <= nxt_idx;
      cfg_data_i    <= nxt_val;
    end
  end

  // Checker: compare each accepted result word with the oldest predicted match
  always @(posedge clk_i) begin : match_check
    match_t                want;
    logic [OUT_DATA_W-1:0] d;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        d = m_axis_tdata;
        if (pending_matches.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result word %h", d);
        end else begin
          want = pending_matches.pop_front();
          n_seen++;
          if (d[17:0] !== want.ep_index || d[35:18] !== want.row_index ||
              d[53:36] !== want.ip_index || d[58:54] !== want.disp_x ||
              d[63:59] !== want.disp_y || d[68:64] !== want.disp_z) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("result %0d: want ep %0d row %0d ip %0d disp %0d/%0d/%0d",
                       n_seen, want.ep_index, want.row_index, want.ip_index,
                       $signed(want.disp_x), $signed(want.disp_y), $signed(want.disp_z));
              $display("  got ep %0d row %0d ip %0d disp %0d/%0d/%0d",
                       d[17:0], d[35:18], d[53:36],
                       $signed(d[58:54]), $signed(d[63:59]), $signed(d[68:64]));
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[idle_phase]);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    n_cycles++;
    if (n_cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d matches outstanding",
               n_cycles, pending_matches.size());
      $display("ellipsoid_neighbour_mask_match: mismatch");
      $finish;
    end
  end

endmodule
